FILE: sv/bcgd_pkg.sv
// ----------------------------------------------------------------------------
// bcgd_pkg
// Shared types and constants of the button chord and gesture decoder.
// ----------------------------------------------------------------------------
package bcgd_pkg;

	localparam int NUM_BTN     = 5;
	localparam int BTN_SENS_DN = 0;
	localparam int BTN_SENS_UP = 1;
	localparam int BTN_MODE    = 2;
	localparam int BTN_VOL_DN  = 3;
	localparam int BTN_VOL_UP  = 4;

	localparam logic [1:0] DOUBLE_CLICKS = 2'd2;
	localparam logic [1:0] TRIPLE_CLICKS = 2'd3;

	typedef enum logic [3:0] {
		EV_NONE,
		EV_SENS_DN,
		EV_SENS_UP,
		EV_MODE,
		EV_VOL_DN,
		EV_VOL_UP,
		EV_DUR_DN,
		EV_DUR_UP,
		EV_ROOT_DN,
		EV_ROOT_UP,
		EV_RAW_TOG,
		EV_MIDI_TOG,
		EV_BEND_TOG,
		EV_BANK_NEXT,
		EV_ENTER,
		EV_BACK
	} event_t;

	typedef enum logic [2:0] {
		CFG_DEBOUNCE,
		CFG_REP_DELAY,
		CFG_REP_PERIOD,
		CFG_LONG_HOLD,
		CFG_CLICK_WIN,
		CFG_CHORD_HOLD
	} cfg_idx_t;

	localparam event_t PLAIN_CODE [NUM_BTN] =
		'{EV_SENS_DN, EV_SENS_UP, EV_MODE, EV_VOL_DN, EV_VOL_UP};
	localparam event_t SHIFT_CODE [NUM_BTN] =
		'{EV_DUR_DN, EV_DUR_UP, EV_NONE, EV_ROOT_DN, EV_ROOT_UP};

	// signed wrapping (now - t) >= lim
	function automatic logic bcgd_reached(input logic [31:0] now, input logic [31:0] t,
		input logic [31:0] lim);
		logic [31:0] d;
		d = now - t;
		return !d[31] && (d >= lim);
	endfunction

	function automatic logic bcgd_in_chord(input int i, input logic sens_act,
		input logic vol_act);
		return (sens_act && i <= BTN_SENS_UP) || (vol_act && i >= BTN_VOL_DN);
	endfunction

endpackage

FILE: sv/button_chord_gesture_decoder_unit.sv
// ----------------------------------------------------------------------------
// button_chord_gesture_decoder_unit
// Debounces five buttons per scan and decodes one gesture event per scan.
// ----------------------------------------------------------------------------
//  channel   signals                             direction
//  in        in_valid/in_ready, raw_pressed,     scan beat into the block
//            now_us
//  out       out_valid/out_ready, event_code     one event beat per scan
//  cfg       cfg_we, cfg_idx, cfg_wdata          register write, no wait
//
//  a scan beat lands in the input register, and the decode that follows, once
//  the event register is free, writes the button state and the event register
//  together; one scan per cycle sustained while out_ready holds, set by the
//  single decode path between the input and event registers.
//  reset clears the valid flags and button state and loads the register defaults; no clearing pass.
//  a stalled event holds its register while the input register still takes
//  one more scan.
module button_chord_gesture_decoder_unit
	import bcgd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [4:0]  raw_pressed,
	input  logic [31:0] now_us,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  event_code,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_wdata
);

	// configuration
	logic [2:0]  debounce_q;
	logic [31:0] rep_delay_q, rep_period_q, click_win_q;
	logic [30:0] long_hold_q, chord_hold_q;

	// input stage
	logic        vld_s1;
	logic [4:0]  raw_s1;
	logic [31:0] now_s1;

	// event register
	logic        out_vld_q;
	logic [3:0]  event_q;

	// button state
	logic [NUM_BTN-1:0] stable_q, cand_q, act_done_q, long_done_q;
	logic [2:0]         run_q     [NUM_BTN];
	logic [31:0]        rep_due_q [NUM_BTN];
	logic [31:0]        press_t_q [NUM_BTN];
	logic               used_q, mode_long_q, pend_q;
	logic [31:0]        mode_t_q, deadline_q;
	logic [1:0]         cnt_q;
	logic               sens_act_q, sens_done_q, vol_act_q, vol_done_q;
	logic [31:0]        sens_t_q, vol_t_q;

	logic [NUM_BTN-1:0] stable_n, cand_n, act_done_n, long_done_n;
	logic [2:0]         run_n     [NUM_BTN];
	logic [31:0]        rep_due_n [NUM_BTN];
	logic [31:0]        press_t_n [NUM_BTN];
	logic               used_n, mode_long_n, pend_n;
	logic [31:0]        mode_t_n, deadline_n;
	logic [1:0]         cnt_n;
	logic               sens_act_n, sens_done_n, vol_act_n, vol_done_n;
	logic [31:0]        sens_t_n, vol_t_n;

	logic               advance;
	logic [NUM_BTN-1:0] pressed_ev, released_ev;
	logic [2:0]         need;
	logic               hit, mod;
	event_t             ev;

	assign advance   = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready  = !vld_s1 || advance;
	assign out_valid = out_vld_q;
	assign event_code = event_q;

	always_comb begin
		stable_n    = stable_q;
		cand_n      = cand_q;
		act_done_n  = act_done_q;
		long_done_n = long_done_q;
		run_n       = run_q;
		rep_due_n   = rep_due_q;
		press_t_n   = press_t_q;
		used_n      = used_q;
		mode_long_n = mode_long_q;
		pend_n      = pend_q;
		mode_t_n    = mode_t_q;
		deadline_n  = deadline_q;
		cnt_n       = cnt_q;
		sens_act_n  = sens_act_q;
		sens_done_n = sens_done_q;
		vol_act_n   = vol_act_q;
		vol_done_n  = vol_done_q;
		sens_t_n    = sens_t_q;
		vol_t_n     = vol_t_q;
		pressed_ev  = '0;
		released_ev = '0;
		hit         = 1'b0;
		ev          = EV_NONE;
		need        = (debounce_q == 3'd0) ? 3'd1 : debounce_q;
		mod         = 1'b0;

		// debounce
		for (int i = 0; i < NUM_BTN; i++) begin
			if (raw_s1[i] != cand_q[i]) begin
				cand_n[i] = raw_s1[i];
				run_n[i]  = 3'd1;
			end else if (run_q[i] < need) begin
				run_n[i] = run_q[i] + 3'd1;
			end
			if (run_n[i] >= need && raw_s1[i] != stable_q[i]) begin
				stable_n[i] = raw_s1[i];
				if (raw_s1[i]) begin
					pressed_ev[i]  = 1'b1;
					rep_due_n[i]   = now_s1 + rep_delay_q;
					act_done_n[i]  = 1'b0;
					long_done_n[i] = 1'b0;
					press_t_n[i]   = now_s1;
				end else begin
					released_ev[i] = 1'b1;
				end
			end
		end
		mod = stable_n[BTN_MODE];

		if (pressed_ev[BTN_MODE]) begin
			used_n      = 1'b0;
			mode_long_n = 1'b0;
			mode_t_n    = now_s1;
		end

		// chord start
		if (!mod && !sens_act_n && stable_n[BTN_SENS_DN] && stable_n[BTN_SENS_UP]) begin
			sens_act_n  = 1'b1;
			sens_done_n = 1'b0;
			sens_t_n    = now_s1;
			act_done_n[BTN_SENS_DN] = 1'b1;
			act_done_n[BTN_SENS_UP] = 1'b1;
		end
		if (!mod && !vol_act_n && stable_n[BTN_VOL_DN] && stable_n[BTN_VOL_UP]) begin
			vol_act_n  = 1'b1;
			vol_done_n = 1'b0;
			vol_t_n    = now_s1;
			act_done_n[BTN_VOL_DN] = 1'b1;
			act_done_n[BTN_VOL_UP] = 1'b1;
		end

		// chord release, then chord hold
		if (sens_act_n && !stable_n[BTN_SENS_DN] && !stable_n[BTN_SENS_UP]) begin
			sens_act_n  = 1'b0;
			sens_done_n = 1'b0;
			hit         = 1'b1;
		end else if (vol_act_n && !stable_n[BTN_VOL_DN] && !stable_n[BTN_VOL_UP]) begin
			vol_act_n  = 1'b0;
			vol_done_n = 1'b0;
			hit        = 1'b1;
		end else if (sens_act_n && !sens_done_n &&
			bcgd_reached(now_s1, sens_t_n, {1'b0, chord_hold_q})) begin
			sens_done_n = 1'b1;
			hit         = 1'b1;
			ev          = EV_RAW_TOG;
		end else if (vol_act_n && !vol_done_n &&
			bcgd_reached(now_s1, vol_t_n, {1'b0, chord_hold_q})) begin
			vol_done_n = 1'b1;
			hit        = 1'b1;
			ev         = EV_MIDI_TOG;
		end

		// mode-modified press
		for (int i = 0; i < NUM_BTN; i++) begin
			if (!hit && i != BTN_MODE && pressed_ev[i] && mod &&
				!bcgd_in_chord(i, sens_act_n, vol_act_n)) begin
				used_n        = 1'b1;
				pend_n        = 1'b0;
				cnt_n         = 2'd0;
				act_done_n[i] = 1'b1;
				hit           = 1'b1;
				ev            = SHIFT_CODE[i];
			end
		end

		// mode click counting
		if (!hit && released_ev[BTN_MODE] && !used_n) begin
			if (pend_n && !bcgd_reached(deadline_n, now_s1, 32'd0))
				cnt_n = 2'd0;
			cnt_n = cnt_n + 2'd1;
			if (cnt_n >= TRIPLE_CLICKS) begin
				cnt_n  = 2'd0;
				pend_n = 1'b0;
				hit    = 1'b1;
				ev     = EV_MIDI_TOG;
			end else begin
				pend_n     = 1'b1;
				deadline_n = now_s1 + click_win_q;
			end
		end

		// deferred release action
		for (int i = 0; i < NUM_BTN; i++) begin
			if (!hit && released_ev[i] && i != BTN_MODE && !act_done_n[i] &&
				!bcgd_in_chord(i, sens_act_n, vol_act_n)) begin
				act_done_n[i] = 1'b1;
				hit           = 1'b1;
				ev            = PLAIN_CODE[i];
			end
		end

		// mode long hold
		if (!hit && mod && !used_n && !mode_long_n &&
			bcgd_reached(now_s1, mode_t_n, {1'b0, long_hold_q})) begin
			mode_long_n = 1'b1;
			used_n      = 1'b1;
			pend_n      = 1'b0;
			cnt_n       = 2'd0;
			hit         = 1'b1;
			ev          = EV_BEND_TOG;
		end

		// long hold of the sens buttons, then auto-repeat, per button in order
		for (int i = 0; i < NUM_BTN; i++) begin
			if (!hit && i <= BTN_SENS_UP && stable_n[i] && !long_done_n[i] &&
				bcgd_reached(now_s1, press_t_n[i], {1'b0, long_hold_q})) begin
				long_done_n[i] = 1'b1;
				hit            = 1'b1;
				ev             = (i == BTN_SENS_DN) ? EV_ENTER : EV_BACK;
			end
			if (!hit && stable_n[i] && i != BTN_MODE &&
				!bcgd_in_chord(i, sens_act_n, vol_act_n) &&
				bcgd_reached(now_s1, rep_due_n[i], 32'd0)) begin
				rep_due_n[i] = now_s1 + rep_period_q;
				if (mod) begin
					used_n = 1'b1;
					pend_n = 1'b0;
					cnt_n  = 2'd0;
				end
				act_done_n[i] = 1'b1;
				hit           = 1'b1;
				ev            = mod ? SHIFT_CODE[i] : PLAIN_CODE[i];
			end
		end

		// click window expired
		if (!hit && pend_n && !mod && bcgd_reached(now_s1, deadline_n, 32'd0)) begin
			ev     = (cnt_n == DOUBLE_CLICKS) ? EV_BANK_NEXT : EV_MODE;
			pend_n = 1'b0;
			cnt_n  = 2'd0;
			hit    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= 3'd4;
			rep_delay_q  <= 32'd400000;
			rep_period_q <= 32'd120000;
			long_hold_q  <= 31'd900000;
			click_win_q  <= 32'd320000;
			chord_hold_q <= 31'd3000000;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_DEBOUNCE:   debounce_q   <= cfg_wdata[2:0];
				CFG_REP_DELAY:  rep_delay_q  <= cfg_wdata;
				CFG_REP_PERIOD: rep_period_q <= cfg_wdata;
				CFG_LONG_HOLD:  long_hold_q  <= cfg_wdata[30:0];
				CFG_CLICK_WIN:  click_win_q  <= cfg_wdata;
				CFG_CHORD_HOLD: chord_hold_q <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			raw_s1 <= raw_pressed;
			now_s1 <= now_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			event_q <= ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q    <= '0;
			cand_q      <= '0;
			act_done_q  <= '0;
			long_done_q <= '0;
			for (int i = 0; i < NUM_BTN; i++) begin
				run_q[i]     <= 3'd0;
				rep_due_q[i] <= 32'd0;
				press_t_q[i] <= 32'd0;
			end
			used_q      <= 1'b0;
			mode_long_q <= 1'b0;
			pend_q      <= 1'b0;
			mode_t_q    <= 32'd0;
			deadline_q  <= 32'd0;
			cnt_q       <= 2'd0;
			sens_act_q  <= 1'b0;
			sens_done_q <= 1'b0;
			vol_act_q   <= 1'b0;
			vol_done_q  <= 1'b0;
			sens_t_q    <= 32'd0;
			vol_t_q     <= 32'd0;
		end else if (advance) begin
			stable_q    <= stable_n;
			cand_q      <= cand_n;
			act_done_q  <= act_done_n;
			long_done_q <= long_done_n;
			run_q       <= run_n;
			rep_due_q   <= rep_due_n;
			press_t_q   <= press_t_n;
			used_q      <= used_n;
			mode_long_q <= mode_long_n;
			pend_q      <= pend_n;
			mode_t_q    <= mode_t_n;
			deadline_q  <= deadline_n;
			cnt_q       <= cnt_n;
			sens_act_q  <= sens_act_n;
			sens_done_q <= sens_done_n;
			vol_act_q   <= vol_act_n;
			vol_done_q  <= vol_done_n;
			sens_t_q    <= sens_t_n;
			vol_t_q     <= vol_t_n;
		end
	end

endmodule

FILE: sv/bcgd_checker.sv
// ----------------------------------------------------------------------------
// bcgd_checker
// Port-level checks of the button chord and gesture decoder.
// ----------------------------------------------------------------------------
module bcgd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  event_code
);

	// no event beat once reset has been seen at an edge
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("event beat during reset");

	// a stalled event beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_code))
		else $error("stalled event beat changed");

	// an empty event register never blocks the input side
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// an accepted scan beat moves from the input register into the event register when nothing stalls it
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready ##1 (!out_valid || out_ready) |=> out_valid)
		else $error("scan beat produced no event beat");

endmodule

bind button_chord_gesture_decoder_unit bcgd_checker u_bcgd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.event_code  (event_code)
);

FILE: bench/button_chord_gesture_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_chord_gesture_decoder_unit_tb
// Self-checking bench for the button chord and gesture decoder. Scans are
// queued by phase, sent by a driver with random gaps, and each event beat is
// checked against an in-bench decoder model updated at every accepted scan.
// Registers are reprogrammed between phases while the block is idle.
// ----------------------------------------------------------------------------
module button_chord_gesture_decoder_unit_tb;
	import bcgd_pkg::*;

	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;
	localparam int         LONG_STALL_AT = 150;
	localparam int         LONG_STALL_CYCLES = 300;

	typedef struct packed {
		logic [4:0]  buttons;
		logic [31:0] stamp;
	} scan_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [4:0]  raw_pressed = '0;
	logic [31:0] now_us = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  event_code;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_idx = '0;
	logic [31:0] cfg_wdata = '0;

	button_chord_gesture_decoder_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.raw_pressed(raw_pressed),
		.now_us     (now_us),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_code (event_code),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata)
	);

	always #6 clk = ~clk;

	// decoder model: registers
	logic [2:0]  reg_debounce;
	logic [31:0] reg_rep_delay, reg_rep_period, reg_click_win;
	logic [30:0] reg_long_hold, reg_chord_hold;

	// decoder model: button and gesture state
	logic [4:0]  lvl_stable, lvl_cand, act_done, lng_done;
	logic [2:0]  run_len [NUM_BTN];
	logic [31:0] rep_due [NUM_BTN];
	logic [31:0] t_press [NUM_BTN];
	logic        mode_used, mode_long, click_pend;
	logic [31:0] mode_t0, click_due;
	logic [1:0]  clicks;
	logic        sens_on, sens_fired, vol_on, vol_fired;
	logic [31:0] sens_t0, vol_t0;

	scan_t  scans_to_send [$];
	event_t pending_events [$];
	scan_t  next_scan;
	event_t want_event;
	int     bad_count = 0;
	int     events_seen = 0;
	int     gap_left = 0;
	bit     tx_burst = 1'b0;
	int     stall_left = 0;
	bit     rx_burst = 1'b0;
	bit     long_stall_done = 1'b0;

	// stimulus generator state
	logic [31:0] gen_time = '0;
	int unsigned step_lo, step_hi, step_big;
	int          scans_made = 0;

	function automatic void init_model();
		int b;
		reg_debounce   = 3'd4;
		reg_rep_delay  = 32'd400000;
		reg_rep_period = 32'd120000;
		reg_long_hold  = 31'd900000;
		reg_click_win  = 32'd320000;
		reg_chord_hold = 31'd3000000;
		lvl_stable = '0;
		lvl_cand   = '0;
		act_done   = '0;
		lng_done   = '0;
		for (b = 0; b < NUM_BTN; b++) begin
			run_len[b] = '0;
			rep_due[b] = '0;
			t_press[b] = '0;
		end
		mode_used  = 1'b0;
		mode_long  = 1'b0;
		mode_t0    = '0;
		click_pend = 1'b0;
		click_due  = '0;
		clicks     = '0;
		sens_on    = 1'b0;
		sens_fired = 1'b0;
		sens_t0    = '0;
		vol_on     = 1'b0;
		vol_fired  = 1'b0;
		vol_t0     = '0;
	endfunction

	// (now - since) as signed 32-bit, not negative and at least lim
	function automatic logic elapsed(input logic [31:0] now, input logic [31:0] since,
		input logic [31:0] lim);
		logic [31:0] diff;
		diff = now - since;
		return ($signed(diff) >= 0) && (diff >= lim);
	endfunction

	function automatic logic chord_owns(input int b);
		return (sens_on && b <= BTN_SENS_UP) || (vol_on && b >= BTN_VOL_DN);
	endfunction

	function automatic void drop_clicks();
		mode_used  = 1'b1;
		click_pend = 1'b0;
		clicks     = '0;
	endfunction

	function automatic event_t decode_scan(input logic [4:0] raw, input logic [31:0] now);
		int         b;
		logic [4:0] pressed_now, released_now;
		logic [2:0] need;
		logic       shifted;
		logic [1:0] n;
		pressed_now  = '0;
		released_now = '0;
		need = (reg_debounce == 3'd0) ? 3'd1 : reg_debounce;

		for (b = 0; b < NUM_BTN; b++) begin
			if (raw[b] != lvl_cand[b]) begin
				lvl_cand[b] = raw[b];
				run_len[b]  = 3'd1;
			end else if (run_len[b] < need) begin
				run_len[b] = run_len[b] + 3'd1;
			end
			if (run_len[b] >= need && raw[b] != lvl_stable[b]) begin
				lvl_stable[b] = raw[b];
				if (raw[b]) begin
					pressed_now[b] = 1'b1;
					rep_due[b]     = now + reg_rep_delay;
					act_done[b]    = 1'b0;
					lng_done[b]    = 1'b0;
					t_press[b]     = now;
				end else begin
					released_now[b] = 1'b1;
				end
			end
		end

		if (pressed_now[BTN_MODE]) begin
			mode_used = 1'b0;
			mode_long = 1'b0;
			mode_t0   = now;
		end

		// pairs only form a chord while mode is up
		if (!lvl_stable[BTN_MODE] && !sens_on && lvl_stable[BTN_SENS_DN] &&
			lvl_stable[BTN_SENS_UP]) begin
			sens_on    = 1'b1;
			sens_fired = 1'b0;
			sens_t0    = now;
			act_done[BTN_SENS_DN] = 1'b1;
			act_done[BTN_SENS_UP] = 1'b1;
		end
		if (!lvl_stable[BTN_MODE] && !vol_on && lvl_stable[BTN_VOL_DN] &&
			lvl_stable[BTN_VOL_UP]) begin
			vol_on    = 1'b1;
			vol_fired = 1'b0;
			vol_t0    = now;
			act_done[BTN_VOL_DN] = 1'b1;
			act_done[BTN_VOL_UP] = 1'b1;
		end

		if (sens_on && !lvl_stable[BTN_SENS_DN] && !lvl_stable[BTN_SENS_UP]) begin
			sens_on    = 1'b0;
			sens_fired = 1'b0;
			return EV_NONE;
		end
		if (vol_on && !lvl_stable[BTN_VOL_DN] && !lvl_stable[BTN_VOL_UP]) begin
			vol_on    = 1'b0;
			vol_fired = 1'b0;
			return EV_NONE;
		end
		if (sens_on && !sens_fired && elapsed(now, sens_t0, {1'b0, reg_chord_hold})) begin
			sens_fired = 1'b1;
			return EV_RAW_TOG;
		end
		if (vol_on && !vol_fired && elapsed(now, vol_t0, {1'b0, reg_chord_hold})) begin
			vol_fired = 1'b1;
			return EV_MIDI_TOG;
		end

		// a press with mode held fires at once, plain presses wait for release
		for (b = 0; b < NUM_BTN; b++) begin
			if (b != BTN_MODE && pressed_now[b] && !chord_owns(b) &&
				lvl_stable[BTN_MODE]) begin
				drop_clicks();
				act_done[b] = 1'b1;
				return SHIFT_CODE[b];
			end
		end

		if (released_now[BTN_MODE] && !mode_used) begin
			if (click_pend && !elapsed(click_due, now, 32'd0))
				clicks = '0;
			clicks = clicks + 2'd1;
			if (clicks >= TRIPLE_CLICKS) begin
				clicks     = '0;
				click_pend = 1'b0;
				return EV_MIDI_TOG;
			end
			click_pend = 1'b1;
			click_due  = now + reg_click_win;
		end

		for (b = 0; b < NUM_BTN; b++) begin
			if (released_now[b] && b != BTN_MODE && !act_done[b] && !chord_owns(b)) begin
				act_done[b] = 1'b1;
				return PLAIN_CODE[b];
			end
		end

		if (lvl_stable[BTN_MODE] && !mode_used && !mode_long &&
			elapsed(now, mode_t0, {1'b0, reg_long_hold})) begin
			mode_long = 1'b1;
			drop_clicks();
			return EV_BEND_TOG;
		end

		for (b = 0; b < NUM_BTN; b++) begin
			if (b <= BTN_SENS_UP && lvl_stable[b] && !lng_done[b] &&
				elapsed(now, t_press[b], {1'b0, reg_long_hold})) begin
				lng_done[b] = 1'b1;
				return (b == BTN_SENS_DN) ? EV_ENTER : EV_BACK;
			end
			if (lvl_stable[b] && b != BTN_MODE && !chord_owns(b) &&
				elapsed(now, rep_due[b], 32'd0)) begin
				shifted    = lvl_stable[BTN_MODE];
				rep_due[b] = now + reg_rep_period;
				if (shifted)
					drop_clicks();
				act_done[b] = 1'b1;
				return shifted ? SHIFT_CODE[b] : PLAIN_CODE[b];
			end
		end

		if (click_pend && !lvl_stable[BTN_MODE] && elapsed(now, click_due, 32'd0)) begin
			n          = clicks;
			click_pend = 1'b0;
			clicks     = '0;
			return (n == DOUBLE_CLICKS) ? EV_BANK_NEXT : EV_MODE;
		end
		return EV_NONE;
	endfunction

	function automatic void flag_error(input string msg);
		bad_count++;
		if (bad_count <= 10)
			$display("error: %s", msg);
	endfunction

	function automatic int pick_gap(input bit burst);
		int unsigned r;
		r = $urandom_range(99, 0);
		if (burst || r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(3, 1);
		else if (r < 97)
			return $urandom_range(10, 4);
		else
			return $urandom_range(80, 20);
	endfunction

	// driver: one scan beat per handshake, payload held while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			raw_pressed <= '0;
			now_us      <= '0;
			gap_left    <= 0;
			tx_burst    <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				pending_events.push_back(decode_scan(raw_pressed, now_us));
			if (!(in_valid && !in_ready)) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (scans_to_send.size() != 0) begin
					next_scan = scans_to_send.pop_front();
					in_valid    <= 1'b1;
					raw_pressed <= next_scan.buttons;
					now_us      <= next_scan.stamp;
					gap_left    <= pick_gap(tx_burst);
				end else begin
					in_valid <= 1'b0;
				end
				if ($urandom_range(49, 0) == 0)
					tx_burst <= !tx_burst;
			end
		end
	end

	// receiver back-pressure, with one long hold-off to fill the block
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready       <= 1'b0;
			stall_left      <= 0;
			rx_burst        <= 1'b0;
			long_stall_done <= 1'b0;
		end else if (!long_stall_done && events_seen >= LONG_STALL_AT) begin
			long_stall_done <= 1'b1;
			stall_left      <= LONG_STALL_CYCLES;
			out_ready       <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else begin
			if ($urandom_range(99, 0) == 0)
				rx_burst <= !rx_burst;
			if (rx_burst) begin
				out_ready <= 1'b1;
			end else begin
				case ($urandom_range(99, 0)) inside
					[0:14]: begin
						out_ready  <= 1'b0;
						stall_left <= $urandom_range(2, 0);
					end
					[15:17]: begin
						out_ready  <= 1'b0;
						stall_left <= $urandom_range(10, 4);
					end
					18: begin
						out_ready  <= 1'b0;
						stall_left <= $urandom_range(60, 20);
					end
					default: out_ready <= 1'b1;
				endcase
			end
		end
	end

	// monitor: every event beat against the oldest predicted event
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			events_seen <= events_seen + 1;
			if (pending_events.size() == 0) begin
				flag_error($sformatf("event %0d with no scan outstanding", event_code));
			end else begin
				want_event = pending_events.pop_front();
				if (event_code !== want_event)
					flag_error($sformatf("event %0d: expected %0d (%s) got %0d",
						events_seen, want_event, want_event.name(), event_code));
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_DEBOUNCE:   reg_debounce   = val[2:0];
			CFG_REP_DELAY:  reg_rep_delay  = val;
			CFG_REP_PERIOD: reg_rep_period = val;
			CFG_LONG_HOLD:  reg_long_hold  = val[30:0];
			CFG_CLICK_WIN:  reg_click_win  = val;
			CFG_CHORD_HOLD: reg_chord_hold = val[30:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic program_regs(input logic [31:0] deb, input logic [31:0] dly,
		input logic [31:0] per, input logic [31:0] lng, input logic [31:0] win,
		input logic [31:0] chd);
		write_reg(CFG_DEBOUNCE, deb);
		write_reg(CFG_REP_DELAY, dly);
		write_reg(CFG_REP_PERIOD, per);
		write_reg(CFG_LONG_HOLD, lng);
		write_reg(CFG_CLICK_WIN, win);
		write_reg(CFG_CHORD_HOLD, chd);
		write_reg(REG_SPARE_A, $urandom);
		write_reg(REG_SPARE_B, $urandom);
	endtask

	// wait for every queued scan to be sent and every event to come back
	task automatic wait_idle();
		do
			@(negedge clk);
		while (scans_to_send.size() != 0 || in_valid || pending_events.size() != 0);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic void push_scan(input logic [4:0] m, input logic [31:0] t);
		scan_t s;
		s.buttons = m;
		s.stamp   = t;
		scans_to_send.push_back(s);
		scans_made++;
	endfunction

	function automatic void tick_stamp();
		int unsigned r;
		r = $urandom_range(99, 0);
		if (r < 90)
			gen_time += $urandom_range(step_hi, step_lo);
		else if (r < 96)
			gen_time += $urandom_range(step_big, 0);
		else if (r < 98)
			gen_time -= $urandom_range(step_hi, 0);
		else
			gen_time += 32'h8000_0000 + $urandom;
	endfunction

	// hold a button mask for n scans, with an occasional one-scan bounce
	function automatic void hold_mask(input logic [4:0] mask, input int n);
		int         k;
		logic [4:0] m;
		for (k = 0; k < n; k++) begin
			m = mask;
			if ($urandom_range(24, 0) == 0)
				m ^= 5'b1 << $urandom_range(4, 0);
			tick_stamp();
			push_scan(m, gen_time);
		end
	endfunction

	function automatic logic [4:0] pick_plain_button();
		case ($urandom_range(3, 0))
			0:       return 5'b1 << BTN_SENS_DN;
			1:       return 5'b1 << BTN_SENS_UP;
			2:       return 5'b1 << BTN_VOL_DN;
			default: return 5'b1 << BTN_VOL_UP;
		endcase
	endfunction

	task automatic gen_gestures(input int n);
		int         start, k, r;
		logic [4:0] b, pair, mode_bit;
		start    = scans_made;
		mode_bit = 5'b1 << BTN_MODE;
		while (scans_made - start < n) begin
			r = $urandom_range(99, 0);
			if (r < 20) begin
				hold_mask(pick_plain_button(), $urandom_range(40, 1));
				hold_mask('0, $urandom_range(12, 1));
			end else if (r < 35) begin
				b = pick_plain_button();
				hold_mask(mode_bit, $urandom_range(8, 1));
				hold_mask(mode_bit | b, $urandom_range(30, 1));
				hold_mask($urandom_range(1, 0) ? mode_bit : b, $urandom_range(8, 1));
				hold_mask('0, $urandom_range(10, 1));
			end else if (r < 50) begin
				for (k = $urandom_range(3, 1); k > 0; k--) begin
					hold_mask(mode_bit, $urandom_range(10, 1));
					hold_mask('0, $urandom_range(10, 1));
				end
				hold_mask('0, $urandom_range(20, 1));
			end else if (r < 63) begin
				pair = $urandom_range(1, 0) ? 5'b00011 : 5'b11000;
				hold_mask(pair & ($urandom_range(1, 0) ? 5'b01001 : 5'b10010),
					$urandom_range(3, 0));
				hold_mask(pair, $urandom_range(60, 1));
				hold_mask(pair & ($urandom_range(1, 0) ? 5'b01001 : 5'b10010),
					$urandom_range(4, 0));
				hold_mask('0, $urandom_range(8, 1));
			end else if (r < 73) begin
				hold_mask(mode_bit, $urandom_range(50, 5));
				hold_mask('0, $urandom_range(10, 1));
			end else if (r < 83) begin
				hold_mask(5'b1 << $urandom_range(1, 0), $urandom_range(50, 5));
				hold_mask('0, $urandom_range(10, 1));
			end else if (r < 92) begin
				hold_mask(5'($urandom_range(31, 0)), $urandom_range(30, 1));
			end else begin
				for (k = $urandom_range(12, 3); k > 0; k--)
					hold_mask(5'($urandom_range(31, 0)), 1);
			end
		end
	endtask

	initial begin
		init_model();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: zero debounce acts as one, short thresholds
		program_regs(32'd0, 32'd100, 32'd50, 32'd300, 32'd200, 32'd500);
		push_scan(5'b00000, 32'd0);
		push_scan(5'b00001, 32'd10);
		push_scan(5'b00000, 32'd20);     // deferred plain action on release
		push_scan(5'b00100, 32'd30);
		push_scan(5'b00101, 32'd40);     // mode-modified press
		push_scan(5'b00000, 32'd50);
		push_scan(5'b00100, 32'd60);
		push_scan(5'b00000, 32'd70);
		push_scan(5'b00100, 32'd80);
		push_scan(5'b00000, 32'd90);
		push_scan(5'b00000, 32'd400);    // double click resolves
		push_scan(5'b00100, 32'd410);
		push_scan(5'b00000, 32'd420);
		push_scan(5'b00100, 32'd430);
		push_scan(5'b00000, 32'd440);
		push_scan(5'b00100, 32'd450);
		push_scan(5'b00000, 32'd460);    // triple click
		push_scan(5'b00011, 32'd470);
		push_scan(5'b00011, 32'd1000);   // sens chord toggle
		push_scan(5'b11000, 32'd1010);
		push_scan(5'b11000, 32'd1600);   // vol chord toggle
		push_scan(5'b00010, 32'd1610);
		push_scan(5'b00010, 32'd1950);   // long hold
		push_scan(5'b00110, 32'd1960);   // modified repeat
		push_scan(5'b00110, 32'd2300);   // another modified repeat; no mode long hold once mode was used
		push_scan(5'b11111, 32'hFFFF_FFFF);
		wait_idle();

		program_regs(32'd1, 32'd2000, 32'd1000, 32'd5000, 32'd3000, 32'd12000);
		step_lo = 100; step_hi = 1500; step_big = 30000;
		gen_time = $urandom;
		gen_gestures(225);
		wait_idle();

		// every threshold at zero, longest debounce
		program_regs(32'd7, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		step_lo = 0; step_hi = 50; step_big = 500;
		gen_gestures(225);
		wait_idle();

		// every register but debounce at its top, upper bits beyond the widths set
		program_regs(32'hFFFF_FFF3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		step_lo = 1000; step_hi = 32'h0010_0000; step_big = 32'h7FFF_FFFF;
		gen_gestures(225);
		wait_idle();

		// timestamps run across the wrap
		program_regs(32'd2, 32'd30000, 32'd8000, 32'd60000, 32'd25000, 32'd150000);
		step_lo = 1000; step_hi = 9000; step_big = 600000;
		gen_time = 32'hFFFF_0000;
		gen_gestures(225);
		wait_idle();

		// back to the reset values
		program_regs(32'd4, 32'd400000, 32'd120000, 32'd900000, 32'd320000, 32'd3000000);
		step_lo = 5000; step_hi = 60000; step_big = 12000000;
		gen_gestures(225);
		wait_idle();

		program_regs($urandom_range(7, 1), $urandom_range(20000, 500),
			$urandom_range(5000, 200), $urandom_range(40000, 1000),
			$urandom_range(15000, 500), $urandom_range(80000, 2000));
		step_lo = 100; step_hi = 3000; step_big = 200000;
		gen_gestures(225);
		wait_idle();

		repeat (8) @(posedge clk);
		if (pending_events.size() != 0)
			flag_error($sformatf("%0d events never arrived", pending_events.size()));
		if (bad_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#10ms;
		$display("timeout waiting for event beats");
		$display("*** FAILED ***");
		$finish;
	end

endmodule
